// ===== rtl/lsh_pkg.sv =====
// Shared types, codes and constants of the link set-up handshake.
`default_nettype none

package lsh_pkg;

   // Field widths
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int TICK_W   = 16;
   localparam int ATT_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Frame layout
   localparam logic [BYTE_W-1:0] FRAME_FLAG = 8'h7E;
   localparam int FRAME_LEN  = 5;
   localparam int BEAT_W     = 3;
   localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(FRAME_LEN - 1);

   // Register reset values
   localparam logic [BYTE_W-1:0] ADDRESS_RST     = 8'h03;
   localparam logic [BYTE_W-1:0] SET_CONTROL_RST = 8'h03;
   localparam logic [BYTE_W-1:0] UA_CONTROL_RST  = 8'h05;
   localparam logic [TICK_W-1:0] TIMEOUT_RST     = 16'd3;
   localparam logic [ATT_W-1:0]  MAX_ATT_RST     = 4'd3;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDRESS     = 3'd0,
      CSR_SET_CONTROL = 3'd1,
      CSR_UA_CONTROL  = 3'd2,
      CSR_TIMEOUT     = 3'd3,
      CSR_MAX_ATT     = 3'd4
   } csr_index_type;

   // Operation codes of an input item
   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_RX    = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Link status codes as seen on the result channel
   typedef enum logic [STATUS_W-1:0] {
      STATUS_IDLE = 2'd0,
      STATUS_WAIT = 2'd1,
      STATUS_CONN = 2'd2,
      STATUS_FAIL = 2'd3
   } status_type;

   // Link state machine
   typedef enum logic [3:0] {
      LINK_IDLE = 4'b0001,
      LINK_WAIT = 4'b0010,
      LINK_CONN = 4'b0100,
      LINK_FAIL = 4'b1000
   } link_type;

   // Reply frame recognizer
   typedef enum logic [4:0] {
      REC_START = 5'b00001,
      REC_FLAG  = 5'b00010,
      REC_ADDR  = 5'b00100,
      REC_CTRL  = 5'b01000,
      REC_BCC   = 5'b10000
   } rec_type;

   function automatic logic [STATUS_W-1:0] link_status(input link_type st);
      logic [STATUS_W-1:0] code;
      unique case (st)
         LINK_IDLE: code = STATUS_IDLE;
         LINK_WAIT: code = STATUS_WAIT;
         LINK_CONN: code = STATUS_CONN;
         LINK_FAIL: code = STATUS_FAIL;
         default:   code = STATUS_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lsh_req_if.sv =====
// Request channel of the link set-up handshake: operation and received byte.
`default_nettype none

interface lsh_req_if
   import lsh_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, operation, rx_byte, input ready);
   modport sink   (input valid, operation, rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/lsh_rsp_if.sv =====
// Response channel of the link set-up handshake: frame bytes and link status.
`default_nettype none

interface lsh_rsp_if
   import lsh_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   tx_byte;
   logic                tx_valid;
   logic                last;
   logic [STATUS_W-1:0] link_status;

   modport source (output valid, tx_byte, tx_valid, last, link_status, input ready);
   modport sink   (input valid, tx_byte, tx_valid, last, link_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/link_setup_handshake.sv =====
// Sender side of a SET/UA link set-up handshake with a UA reply recognizer.
//
// Channels: req_ch carries one item per event (start, received line byte or
// timer tick); rsp_ch returns the results of each item in order. A start, or
// a timeout that still has attempts left, returns the five SET frame bytes
// (flag, address, control, check, flag) as five items with tx_valid set;
// any other item returns one item with tx_valid clear. The last item of each
// input carries last, and every item carries the link status after that input.
// The csr_ port writes the five registers (address, SET control, UA control,
// timeout in ticks, attempt limit) one per cycle; write them only while idle.
// An item's first result is registered; it shows the cycle after acceptance.
// Throughput: one input item per cycle while results are single and the
// receiver takes them; an item that sends a frame holds the single output
// register for all five frame bytes; the next item waits for the last one.
// Reset (synchronous, active high) puts the link in idle, the recognizer at
// start, the counters at zero and the registers at their default values.
// When the receiver stalls, the output register holds its item and req_ch
// takes a new item only in the cycle that frees it.
`default_nettype none

module link_setup_handshake
   import lsh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lsh_req_if.sink                    req_ch,
   lsh_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [BYTE_W-1:0] address_ff;
   logic [BYTE_W-1:0] set_control_ff;
   logic [BYTE_W-1:0] ua_control_ff;
   logic [TICK_W-1:0] timeout_ff;
   logic [ATT_W-1:0]  max_att_ff;

   // Handshake state
   link_type          link_ff, link_in;
   rec_type           rec_ff, rec_in;
   logic [ATT_W-1:0]  att_ff, att_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] tick_inc;
   logic              send_frame;

   // Output register
   logic                out_valid_ff;
   logic                frame_ff;
   logic [BEAT_W-1:0]   beat_ff;
   logic [BYTE_W-1:0]   addr_q_ff;
   logic [BYTE_W-1:0]   ctrl_q_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                out_last;
   logic                req_accept;
   logic                rsp_take;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff     <= ADDRESS_RST;
         set_control_ff <= SET_CONTROL_RST;
         ua_control_ff  <= UA_CONTROL_RST;
         timeout_ff     <= TIMEOUT_RST;
         max_att_ff     <= MAX_ATT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ADDRESS:     address_ff     <= csr_wdata[BYTE_W-1:0];
            CSR_SET_CONTROL: set_control_ff <= csr_wdata[BYTE_W-1:0];
            CSR_UA_CONTROL:  ua_control_ff  <= csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT:     timeout_ff     <= csr_wdata[TICK_W-1:0];
            CSR_MAX_ATT:     max_att_ff     <= csr_wdata[ATT_W-1:0];
            default: ;
         endcase
      end
   end

   // Free the output register on its last result
   assign out_last     = !frame_ff || (beat_ff == BEAT_LAST);
   assign rsp_take     = out_valid_ff && rsp_ch.ready;
   assign req_ch.ready = !out_valid_ff || (rsp_ch.ready && out_last);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign tick_inc     = tick_ff + TICK_W'(1);

   // Advance the handshake for one accepted item
   always_comb begin
      link_in    = link_ff;
      rec_in     = rec_ff;
      att_in     = att_ff;
      tick_in    = tick_ff;
      send_frame = 1'b0;
      if (req_accept) begin
         unique case (req_ch.operation)
            OP_START: begin
               rec_in     = REC_START;
               att_in     = ATT_W'(1);
               tick_in    = '0;
               link_in    = LINK_WAIT;
               send_frame = 1'b1;
            end
            OP_RX: begin
               if (link_ff == LINK_WAIT) begin
                  if (req_ch.rx_byte == FRAME_FLAG) begin
                     if (rec_ff == REC_BCC) begin
                        rec_in  = REC_START;
                        link_in = LINK_CONN;
                     end else begin
                        rec_in = REC_FLAG;
                     end
                  end else begin
                     unique case (rec_ff)
                        REC_FLAG: rec_in = (req_ch.rx_byte == address_ff) ?
                                           REC_ADDR : REC_START;
                        REC_ADDR: rec_in = (req_ch.rx_byte == ua_control_ff) ?
                                           REC_CTRL : REC_START;
                        REC_CTRL: rec_in = (req_ch.rx_byte ==
                                            (address_ff ^ ua_control_ff)) ?
                                           REC_BCC : REC_START;
                        default:  rec_in = REC_START;
                     endcase
                  end
               end
            end
            OP_TICK: begin
               if (link_ff == LINK_WAIT) begin
                  if (tick_inc >= timeout_ff) begin
                     tick_in = '0;
                     if (att_ff >= max_att_ff) begin
                        link_in = LINK_FAIL;
                     end else begin
                        att_in     = att_ff + ATT_W'(1);
                        send_frame = 1'b1;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Hold handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_IDLE;
         rec_ff  <= REC_START;
         att_ff  <= '0;
         tick_ff <= '0;
      end else begin
         link_ff <= link_in;
         rec_ff  <= rec_in;
         att_ff  <= att_in;
         tick_ff <= tick_in;
      end
   end

   // Load the output register on accept, step frame beats as they drain
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         frame_ff     <= 1'b0;
         beat_ff      <= '0;
      end else if (req_accept) begin
         out_valid_ff <= 1'b1;
         frame_ff     <= send_frame;
         beat_ff      <= '0;
      end else if (rsp_take) begin
         if (out_last) begin
            out_valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + BEAT_W'(1);
         end
      end
   end

   // Capture frame payload and status with the item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_q_ff <= address_ff;
         ctrl_q_ff <= set_control_ff;
         status_ff <= link_status(link_in);
      end
   end

   // Select the frame byte for the current beat
   always_comb begin
      rsp_ch.tx_byte = '0;
      if (frame_ff) begin
         unique case (beat_ff)
            3'd0:    rsp_ch.tx_byte = FRAME_FLAG;
            3'd1:    rsp_ch.tx_byte = addr_q_ff;
            3'd2:    rsp_ch.tx_byte = ctrl_q_ff;
            3'd3:    rsp_ch.tx_byte = addr_q_ff ^ ctrl_q_ff;
            3'd4:    rsp_ch.tx_byte = FRAME_FLAG;
            default: rsp_ch.tx_byte = '0;
         endcase
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tx_valid    = frame_ff;
   assign rsp_ch.last        = out_last;
   assign rsp_ch.link_status = status_ff;

`ifndef SYNTHESIS
   // A start always answers with the first frame byte and waiting status
   a_start_sends: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_ch.operation == OP_START) |=>
         rsp_ch.valid && rsp_ch.tx_valid && (rsp_ch.tx_byte == FRAME_FLAG) &&
         (rsp_ch.link_status == STATUS_WAIT))
      else $error("start item did not begin a SET frame");

   // A failed link stays failed until restarted
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (link_ff == LINK_FAIL) && !(req_accept && (req_ch.operation == OP_START)) |=>
         (link_ff == LINK_FAIL))
      else $error("failed link left failure without a start");

   // An empty output register always takes a new item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty output register");

   // A stalled frame byte stays in place
   a_beat_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> $stable(beat_ff) && out_valid_ff)
      else $error("frame beat moved while output stalled");
`endif

endmodule

`default_nettype wire
